>>> design/rn_pkg.sv
// ----------------------------------------------------------------------------
// rn_pkg
// Types, step codes and the control store of the rational normaliser.
// ----------------------------------------------------------------------------
package rn_pkg;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  // Step addresses of the control program
  localparam step_t ST_LOAD = 4'd0;
  localparam step_t ST_CHK  = 4'd1;
  localparam step_t ST_TEST = 4'd2;
  localparam step_t ST_KREM = 4'd3;
  localparam step_t ST_WREM = 4'd4;
  localparam step_t ST_KQN  = 4'd5;
  localparam step_t ST_WQN  = 4'd6;
  localparam step_t ST_KQD  = 4'd7;
  localparam step_t ST_WQD  = 4'd8;
  localparam step_t ST_OUT  = 4'd9;

  typedef enum logic [1:0] {
    DS_REM = 2'd0,
    DS_NUM = 2'd1,
    DS_DEN = 2'd2
  } div_sel_t;

  typedef enum logic [2:0] {
    WB_NONE = 3'd0,
    WB_LOAD = 3'd1,
    WB_SWAP = 3'd2,
    WB_NUM  = 3'd3,
    WB_DEN  = 3'd4,
    WB_OUT  = 3'd5
  } wb_t;

  typedef enum logic [2:0] {
    C_ALWAYS = 3'd0,
    C_IN     = 3'd1,
    C_TRIV   = 3'd2,
    C_BZERO  = 3'd3,
    C_DONE   = 3'd4,
    C_OFREE  = 3'd5
  } cond_t;

  typedef struct packed {
    logic     in_rdy;
    logic     div_go;
    div_sel_t div_sel;
    wb_t      wb;
    cond_t    cond;
    logic     hold;
    step_t    target;
  } cw_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic cw_t ucode(input step_t step);
    cw_t cw;
    cw = '{1'b0, 1'b0, DS_REM, WB_NONE, C_ALWAYS, 1'b0, ST_LOAD};
    unique case (step)
      ST_LOAD: cw = '{1'b1, 1'b0, DS_REM, WB_LOAD, C_IN,     1'b1, ST_CHK};
      ST_CHK:  cw = '{1'b0, 1'b0, DS_REM, WB_NONE, C_TRIV,   1'b0, ST_OUT};
      ST_TEST: cw = '{1'b0, 1'b0, DS_REM, WB_NONE, C_BZERO,  1'b0, ST_KQN};
      ST_KREM: cw = '{1'b0, 1'b1, DS_REM, WB_NONE, C_ALWAYS, 1'b0, ST_WREM};
      ST_WREM: cw = '{1'b0, 1'b0, DS_REM, WB_SWAP, C_DONE,   1'b1, ST_TEST};
      ST_KQN:  cw = '{1'b0, 1'b1, DS_NUM, WB_NONE, C_ALWAYS, 1'b0, ST_WQN};
      ST_WQN:  cw = '{1'b0, 1'b0, DS_NUM, WB_NUM,  C_DONE,   1'b1, ST_KQD};
      ST_KQD:  cw = '{1'b0, 1'b1, DS_DEN, WB_NONE, C_ALWAYS, 1'b0, ST_WQD};
      ST_WQD:  cw = '{1'b0, 1'b0, DS_DEN, WB_DEN,  C_DONE,   1'b1, ST_OUT};
      ST_OUT:  cw = '{1'b0, 1'b0, DS_REM, WB_OUT,  C_OFREE,  1'b1, ST_LOAD};
      default: cw = '{1'b0, 1'b0, DS_REM, WB_NONE, C_ALWAYS, 1'b0, ST_LOAD};
    endcase
    return cw;
  endfunction

endpackage

>>> design/rn_if.sv
// ----------------------------------------------------------------------------
// rn_if
// Valid/ready channels carrying operand and result words.
// ----------------------------------------------------------------------------
interface rn_in_if #(parameter int WIDTH = 32);
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] num_in;
  logic signed [WIDTH-1:0] den_in;

  modport source (output valid, output num_in, output den_in, input ready);
  modport sink   (input valid, input num_in, input den_in, output ready);
endinterface

interface rn_out_if #(parameter int WIDTH = 32);
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] num_out;
  logic        [WIDTH-2:0] den_out;
  logic                    error;

  modport source (output valid, output num_out, output den_out, output error, input ready);
  modport sink   (input valid, input num_out, input den_out, input error, output ready);
endinterface

>>> design/rn_div.sv
// ----------------------------------------------------------------------------
// rn_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rn_div #(
  parameter int W = 31
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [W-1:0]      dividend,
  input  logic [W-1:0]      divisor,
  output logic [W-1:0]      quo,
  output logic [W-1:0]      rem,
  output rn_pkg::div_stat_t stat
);
  import rn_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [W-1:0]  q_r;
  logic [W-1:0]  r_r;
  logic [W-1:0]  dvs_r;
  logic [W:0]    trial;

  assign trial = {r_r, q_r[W-1]} - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q_r   <= dividend;
      r_r   <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      // restore on a negative trial, keep the difference otherwise
      if (trial[W]) begin
        r_r <= {r_r[W-2:0], q_r[W-1]};
      end else begin
        r_r <= trial[W-1:0];
      end
      q_r <= {q_r[W-2:0], ~trial[W]};
    end
  end

  assign quo  = q_r;
  assign rem  = r_r;
  assign stat = '{busy: busy_r, done: done_r};

endmodule

>>> design/rational_normalizer_unit.sv
// ----------------------------------------------------------------------------
// rational_normalizer_unit
// Reduces a signed fraction to lowest terms with Euclid's algorithm.
// ----------------------------------------------------------------------------
// One word at a time: the operands are taken, reduced and the result is held
// in an output register until taken; the next operand word is taken once the
// result has moved into that register. A small control program steps a single
// restoring divider of WIDTH-1 bits. Euclid's loop runs k remainder steps on
// the divider, then two more divisions give the reduced numerator and
// denominator; k is at most about 45 for 32-bit operands and is small for
// typical data. A zero denominator or a most negative operand gives 0/1 with
// error set. The denominator comes out positive, the sign on the numerator.
module rational_normalizer_unit #(
  parameter int WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  rn_in_if.sink    in_bus,
  rn_out_if.source out_bus
);
  import rn_pkg::*;

  localparam int M = WIDTH - 1;

  step_t     upc_r;
  cw_t       cw;
  logic      fire;
  div_stat_t dstat;

  logic [M-1:0] a_r, b_r, na_r, da_r, den_r;
  logic [WIDTH-1:0] num_r;
  logic neg_r, triv_r, err_r;

  logic [M-1:0] dv_a, dv_b, quo, rem;

  logic [WIDTH-1:0] n_in, d_in, n_mag, d_mag, qn_ext;
  logic in_err;

  logic             out_valid_r;
  logic [WIDTH-1:0] out_num_r;
  logic [M-1:0]     out_den_r;
  logic             out_err_r;

  assign cw = ucode(upc_r);

  always_comb begin
    case (cw.cond)
      C_ALWAYS: fire = 1'b1;
      C_IN:     fire = in_bus.valid;
      C_TRIV:   fire = triv_r;
      C_BZERO:  fire = (b_r == '0);
      C_DONE:   fire = dstat.done;
      C_OFREE:  fire = !out_valid_r || out_bus.ready;
      default:  fire = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= ST_LOAD;
    end else if (fire) begin
      upc_r <= cw.target;
    end else if (!cw.hold) begin
      upc_r <= upc_r + step_t'(1);
    end
  end

  // operand decode
  assign n_in   = in_bus.num_in;
  assign d_in   = in_bus.den_in;
  assign n_mag  = n_in[WIDTH-1] ? (~n_in + WIDTH'(1)) : n_in;
  assign d_mag  = d_in[WIDTH-1] ? (~d_in + WIDTH'(1)) : d_in;
  assign in_err = (d_in == '0) || (n_in == {1'b1, {M{1'b0}}}) || (d_in == {1'b1, {M{1'b0}}});
  assign qn_ext = {1'b0, quo};

  always_comb begin
    case (cw.div_sel)
      DS_NUM:  begin dv_a = na_r; dv_b = a_r; end
      DS_DEN:  begin dv_a = da_r; dv_b = a_r; end
      default: begin dv_a = a_r;  dv_b = b_r; end
    endcase
  end

  rn_div #(.W(M)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cw.div_go),
    .dividend (dv_a),
    .divisor  (dv_b),
    .quo      (quo),
    .rem      (rem),
    .stat     (dstat)
  );

  always_ff @(posedge clk) begin
    if (fire) begin
      case (cw.wb)
        WB_LOAD: begin
          na_r   <= n_mag[M-1:0];
          da_r   <= d_mag[M-1:0];
          a_r    <= n_mag[M-1:0];
          b_r    <= d_mag[M-1:0];
          neg_r  <= n_in[WIDTH-1] ^ d_in[WIDTH-1];
          err_r  <= in_err;
          triv_r <= in_err || (n_in == '0);
          num_r  <= '0;
          den_r  <= M'(1);
        end
        WB_SWAP: begin
          a_r <= b_r;
          b_r <= rem;
        end
        WB_NUM:  num_r <= neg_r ? (~qn_ext + WIDTH'(1)) : qn_ext;
        WB_DEN:  den_r <= quo;
        default: ;
      endcase
    end
  end

  // output register: load on the final step, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && cw.wb == WB_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && cw.wb == WB_OUT) begin
      out_num_r <= num_r;
      out_den_r <= den_r;
      out_err_r <= err_r;
    end
  end

  assign in_bus.ready    = cw.in_rdy;
  assign out_bus.valid   = out_valid_r;
  assign out_bus.num_out = out_num_r;
  assign out_bus.den_out = out_den_r;
  assign out_bus.error   = out_err_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_num_r == '0 && out_den_r == M'(1))
    else $error("error result is not 0/1");

  a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_den_r != '0)
    else $error("zero denominator delivered");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cw.div_go |-> !dstat.busy)
    else $error("divider started while busy");

  a_out_ret: assert property (@(posedge clk) disable iff (!rst_n)
    fire && cw.wb == WB_OUT |=> upc_r == ST_LOAD && out_valid_r)
    else $error("result load did not return to operand fetch");

endmodule

>>> tb/rational_normalizer_unit_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_normalizer_unit_chk
// Watches the operand and result channels. For each operand word it works out
// the fraction in lowest terms and queues it, then compares each result word
// with the oldest queued fraction.
// ----------------------------------------------------------------------------
module rational_normalizer_unit_chk #(
  parameter int WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  rn_in_if     in_mon,
  rn_out_if    out_mon,
  output int   fail_count,
  output int   pending
);

  localparam logic [WIDTH-1:0] MOST_NEG   = {1'b1, {(WIDTH-1){1'b0}}};
  localparam int               MAX_REPORT = 10;

  typedef struct packed {
    logic signed [WIDTH-1:0] num;
    logic        [WIDTH-2:0] den;
    logic                    err;
  } fraction_t;

  fraction_t reduced_q[$];

  function automatic fraction_t reduce_fraction(input logic [WIDTH-1:0] n,
                                                input logic [WIDTH-1:0] d);
    fraction_t        r;
    logic [WIDTH-1:0] n_mag, d_mag, a, b, rem, q_num, q_den;
    r.num = '0;
    r.den = (WIDTH-1)'(1);
    r.err = 1'b0;
    if (d == '0 || n == MOST_NEG || d == MOST_NEG) begin
      r.err = 1'b1;
    end else if (n != '0) begin
      n_mag = n[WIDTH-1] ? -n : n;
      d_mag = d[WIDTH-1] ? -d : d;
      a = n_mag;
      b = d_mag;
      // Euclid's remainder loop; a ends as the common divisor
      while (b != '0) begin
        rem = a % b;
        a = b;
        b = rem;
      end
      q_num = n_mag / a;
      q_den = d_mag / a;
      r.den = q_den[WIDTH-2:0];
      r.num = (n[WIDTH-1] ^ d[WIDTH-1]) ? -q_num : q_num;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    fraction_t want, got;
    if (!rst_n) begin
      reduced_q.delete();
      pending <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        reduced_q.push_back(reduce_fraction(in_mon.num_in, in_mon.den_in));
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.num_out, out_mon.den_out, out_mon.error};
        if (reduced_q.size() == 0) begin
          if (fail_count < MAX_REPORT)
            $display("%0t: result word with nothing expected: %0d/%0d err=%0b",
                     $realtime, got.num, got.den, got.err);
          fail_count <= fail_count + 1;
        end else begin
          want = reduced_q.pop_front();
          if (got !== want) begin
            if (fail_count < MAX_REPORT)
              $display("%0t: mismatch: expected %0d/%0d err=%0b, got %0d/%0d err=%0b",
                       $realtime, want.num, want.den, want.err,
                       got.num, got.den, got.err);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= reduced_q.size();
    end
  end

endmodule

>>> tb/rational_normalizer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_normalizer_unit_tb
// Drives operand words into the normaliser: a directed set of edge cases, then
// random fractions, mostly with a planted common factor, under several
// patterns of sender gaps and receiver stalls. The checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module rational_normalizer_unit_tb;

  localparam int               WIDTH       = 32;
  localparam int               PHASE_WORDS = 425;
  localparam int               HOLD_CYCLES = 4000;
  localparam int               STALL_LIMIT = 20000;
  localparam int               DRAIN_WAIT  = 64;
  localparam logic [WIDTH-1:0] MOST_NEG    = {1'b1, {(WIDTH-1){1'b0}}};
  localparam logic [WIDTH-1:0] MOST_POS    = {1'b0, {(WIDTH-1){1'b1}}};

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   sender_idle_pct;
  int   receiver_stall_pct;
  int   holdoff_left;
  int   idle_cycles;
  logic moved;

  rn_in_if  #(.WIDTH(WIDTH)) in_bus ();
  rn_out_if #(.WIDTH(WIDTH)) out_bus ();

  rational_normalizer_unit #(.WIDTH(WIDTH)) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  rational_normalizer_unit_chk #(.WIDTH(WIDTH)) chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  assign moved = (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready);

  // Abort when neither channel moves a word for too long
  always @(posedge clk) begin
    if (!rst_n || moved)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: hold off while a long stall is pending, else stall at random
  initial begin
    out_bus.ready = 1'b0;
    holdoff_left = 0;
    forever begin
      @(negedge clk);
      if (holdoff_left > 0) begin
        out_bus.ready = 1'b0;
        holdoff_left--;
      end else begin
        out_bus.ready = ($urandom_range(99, 0) >= receiver_stall_pct);
      end
    end
  end

  task automatic send_word(input logic [WIDTH-1:0] n, input logic [WIDTH-1:0] d);
    while (sender_idle_pct != 0 && $urandom_range(99, 0) < sender_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid  = 1'b1;
    in_bus.num_in = n;
    in_bus.den_in = d;
    do
      @(posedge clk);
    while (!in_bus.ready);
    @(negedge clk);
  endtask

  task automatic pick_operands(output logic [WIDTH-1:0] n, output logic [WIDTH-1:0] d);
    int unsigned kind, factor, a, b;
    kind = $urandom_range(99, 0);
    if (kind < 55) begin
      // small fractions sharing a planted factor
      factor = $urandom_range(255, 1);
      a = $urandom_range(1023, 0);
      b = $urandom_range(1023, 1);
      n = a * factor;
      d = b * factor;
    end else if (kind < 70) begin
      n = $urandom;
      d = $urandom;
    end else if (kind < 85) begin
      n = $urandom >> $urandom_range(WIDTH-1, 0);
      d = $urandom >> $urandom_range(WIDTH-1, 0);
    end else if (kind < 95) begin
      n = $urandom_range(32, 0) - 16;
      d = $urandom_range(32, 0) - 16;
    end else begin
      n = $urandom;
      d = $urandom;
      case ($urandom_range(2, 0))
        0: d = '0;
        1: n = MOST_NEG;
        default: d = MOST_NEG;
      endcase
    end
    if (kind < 85) begin
      if ($urandom_range(1, 0)) n = -n;
      if ($urandom_range(1, 0)) d = -d;
    end
  endtask

  initial begin
    logic [WIDTH-1:0] n, d;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.num_in = '0;
    in_bus.den_in = '0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // zero numerator, zero denominator and most negative operands
    send_word(0, 5);
    send_word(0, 0);
    send_word(5, 0);
    send_word(MOST_NEG, 3);
    send_word(3, MOST_NEG);
    send_word(0, MOST_NEG);
    send_word(MOST_NEG, MOST_NEG);
    send_word(MOST_NEG, 0);
    // extremes and sign handling
    send_word(MOST_POS, MOST_POS);
    send_word(MOST_POS, -1);
    send_word(-MOST_POS, MOST_POS);
    send_word(1, MOST_POS);
    send_word(-1, -MOST_POS);
    send_word(-1, -1);
    send_word(6, -4);
    send_word(-6, -4);
    send_word(-6, 4);
    send_word(12, 8);
    send_word(MOST_POS - 1, 2);
    // consecutive Fibonacci numbers: the longest remainder chain
    send_word(1836311903, 1134903170);
    send_word(-1134903170, 1836311903);
    send_word(32'h5555_5555, 32'h2AAA_AAAA);
    send_word(32'hAAAA_AAAB, 32'hD555_5556);
    in_bus.valid = 1'b0;
    wait (pending == 0);
    @(negedge clk);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 71; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 71; end
        default: begin sender_idle_pct = 29; receiver_stall_pct = 29; end
      endcase
      // in the first phase, fill the block while the result side holds off
      if (phase == 0) holdoff_left = HOLD_CYCLES;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        pick_operands(n, d);
        send_word(n, d);
      end
      // pause until every result of the phase has come back
      in_bus.valid = 1'b0;
      wait (pending == 0);
      @(negedge clk);
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> files.f
design/rn_pkg.sv
design/rn_if.sv
design/rn_div.sv
design/rational_normalizer_unit.sv
tb/rational_normalizer_unit_chk.sv
tb/rational_normalizer_unit_tb.sv
